// ===== rtl/core/integer_to_ascii_formatter_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter: assertion macros
// Shared checking macros for the formatter RTL.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_UNIT_DEFINES_SVH

// Checks a property on every clock edge outside of reset.
`define ITOA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define ITOA_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

// ===== rtl/core/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter package
// Types, format codes and character constants shared by the formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itoa_pkg;

    // Format selector codes.
    typedef enum logic [1:0] {
        FUNC_SDEC = 2'd0,
        FUNC_UDEC = 2'd1,
        FUNC_HEXL = 2'd2,
        FUNC_HEXU = 2'd3
    } t_func;

    // Character constants.
    localparam logic [7:0] ASCII_ZERO      = 8'd48;
    localparam logic [7:0] ASCII_LOWER_OFS = 8'd87;
    localparam logic [7:0] ASCII_UPPER_OFS = 8'd55;
    localparam logic [7:0] ASCII_MINUS     = 8'd45;

    // Digit buffer and divide-by-ten constants.
    localparam int          DIGITS_MAX = 16;
    localparam int          DIG_IDX_W  = $clog2(DIGITS_MAX);
    localparam logic [31:0] DEC_RECIP  = 32'hCCCC_CCCD;
    localparam int          DEC_SHIFT  = 35;
    localparam logic [3:0]  DEC_RADIX  = 4'd10;

    // Default queue depths.
    localparam int MID_DEPTH_DEF = 2;
    localparam int OUT_DEPTH_DEF = 2;

    // A classified number on its way from the front to the back.
    typedef struct packed {
        logic        hex;
        logic        upper;
        logic        neg;
        logic [63:0] value;
    } t_job;

    // One output character.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic [4:0] count;
    } t_result;

    // Status reported by the back end.
    typedef struct packed {
        logic idle;
        logic push;
        logic pop;
    } t_back_stat;

endpackage

`default_nettype wire

// ===== rtl/core/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// Integer to ASCII formatter unit
// Turns a number and a format selector into a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present i_func and i_value with push; the transfer happens
//   on a clock edge with push high and full low. Formats are signed decimal and
//   unsigned decimal of the low 32 bits, and lower or upper case hexadecimal of
//   all 64 bits.
//   Output channel: while empty is low, o_ch, o_last and o_count show the
//   oldest character; pop transfers it. o_last marks the final character of a
//   number and o_count then holds the length.
//   The back end works on one number at a time: it extracts the digits one
//   per cycle, then emits the characters, any minus sign first, one per
//   cycle while the output queue has room.
//   Numbers queue in the front register and the middle queue while the back end works.
//   A stalled receiver fills the output queue, the back end then holds, and
//   full rises once the middle queue and the front register are occupied.
//   Reset is synchronous and active low; it empties all queues and returns the
//   back end to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "integer_to_ascii_formatter_unit_defines.svh"

module integer_to_ascii_formatter_unit #(
    parameter int MID_DEPTH = itoa_pkg::MID_DEPTH_DEF,
    parameter int OUT_DEPTH = itoa_pkg::OUT_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_func,
    input  wire logic [63:0] i_value,
    output logic             empty,
    input  wire logic        pop,
    output logic [7:0]       o_ch,
    output logic             o_last,
    output logic [4:0]       o_count
);

    import itoa_pkg::*;

    logic       fr_push;
    logic       mid_full;
    t_job       fr_job;
    logic       mid_empty;
    t_job       mid_job;
    t_back_stat bk_stat;
    logic       bk_pop;
    logic       bk_push;
    t_result    bk_res;
    logic       out_full;
    t_result    out_res;

    // Front end: accept and classify.
    itoa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_func     (i_func),
        .i_value    (i_value),
        .o_job_push (fr_push),
        .i_job_full (mid_full),
        .o_job      (fr_job)
    );

    // Queue between front and back.
    itoa_queue #(
        .Width ($bits(t_job)),
        .Depth (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_push),
        .o_full  (mid_full),
        .i_data  (fr_job),
        .i_pop   (bk_pop),
        .o_empty (mid_empty),
        .o_data  (mid_job)
    );

    // Back end: digit extraction and character emission.
    itoa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (~mid_empty),
        .i_job       (mid_job),
        .o_job_pop   (bk_pop),
        .o_res_push  (bk_push),
        .i_res_full  (out_full),
        .o_res       (bk_res),
        .o_stat      (bk_stat)
    );

    // Output queue decouples the receiver from the back end.
    itoa_queue #(
        .Width ($bits(t_result)),
        .Depth (OUT_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (bk_push),
        .o_full  (out_full),
        .i_data  (bk_res),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (out_res)
    );

    assign o_ch    = out_res.ch;
    assign o_last  = out_res.last;
    assign o_count = out_res.count;

    // Checks on the internal handoffs.
    `ITOA_ASSERT(a_pop_not_empty, bk_stat.pop |-> !mid_empty, "Back end popped an empty queue")
    `ITOA_ASSERT(a_push_has_room, bk_stat.push |-> !out_full, "Back end pushed a full queue")
    `ITOA_ASSERT(a_count_nonzero, bk_stat.push |-> (bk_res.count != 5'd0), "Character count is zero")
    `ITOA_ASSERT(a_busy_until_last, (bk_stat.push && !bk_res.last) |=> !bk_stat.idle, "Back end went idle before the last character")

endmodule

`default_nettype wire

// ===== rtl/core/itoa_queue.sv =====
// ----------------------------------------------------------------------------
// Formatter queue
// Small first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_queue #(
    parameter int Width = 8,
    parameter int Depth = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    output logic                  o_full,
    input  wire logic [Width-1:0] i_data,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic      [Width-1:0] o_data
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0] r_mem [Depth];
    logic [PtrW-1:0]  r_wr, n_wr;
    logic [PtrW-1:0]  r_rd, n_rd;
    logic [CntW-1:0]  r_cnt, n_cnt;
    logic             w_do_push;
    logic             w_do_pop;

    // Handshake decode.
    assign o_full    = (r_cnt == CntW'(Depth));
    assign o_empty   = (r_cnt == '0);
    assign w_do_push = i_push & ~o_full;
    assign w_do_pop  = i_pop & ~o_empty;
    assign o_data    = r_mem[r_rd];

    // Pointer and fill count update.
    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (w_do_push) begin
            n_wr = (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd = (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // Storage is written on each push transfer.
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/itoa_front.sv =====
// ----------------------------------------------------------------------------
// Formatter front end
// Accepts numbers, classifies the format and forms the magnitude to print.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [1:0]    i_func,
    input  wire logic [63:0]   i_value,
    output logic               o_job_push,
    input  wire logic          i_job_full,
    output itoa_pkg::t_job     o_job
);

    import itoa_pkg::*;

    logic        r_valid, n_valid;
    t_job        r_job, n_job;
    logic        w_accept;
    t_func       w_func;
    logic [31:0] w_low;

    // The input holds while the staged item cannot enter the queue.
    assign o_full     = r_valid & i_job_full;
    assign w_accept   = i_push & ~o_full;
    assign o_job_push = r_valid;
    assign o_job      = r_job;

    // Classify the format and take the magnitude of a negative signed word.
    always_comb begin
        w_func      = t_func'(i_func);
        w_low       = i_value[31:0];
        n_job.hex   = 1'b0;
        n_job.upper = 1'b0;
        n_job.neg   = 1'b0;
        n_job.value = {32'd0, w_low};
        case (w_func)
            FUNC_SDEC: begin
                if (w_low[31]) begin
                    n_job.neg   = 1'b1;
                    n_job.value = {32'd0, 32'd0 - w_low};
                end
            end
            FUNC_UDEC: begin
                n_job.value = {32'd0, w_low};
            end
            FUNC_HEXL: begin
                n_job.hex   = 1'b1;
                n_job.value = i_value;
            end
            FUNC_HEXU: begin
                n_job.hex   = 1'b1;
                n_job.upper = 1'b1;
                n_job.value = i_value;
            end
            default: begin
                n_job.value = {32'd0, w_low};
            end
        endcase
    end

    assign n_valid = w_accept | (r_valid & i_job_full);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload is captured on each input transfer.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/itoa_back.sv =====
// ----------------------------------------------------------------------------
// Formatter back end
// Extracts digits one per cycle and emits the characters most significant first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itoa_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_job_valid,
    input  wire itoa_pkg::t_job i_job,
    output logic                o_job_pop,
    output logic                o_res_push,
    input  wire logic           i_res_full,
    output itoa_pkg::t_result   o_res,
    output itoa_pkg::t_back_stat o_stat
);

    import itoa_pkg::*;

    localparam int QuotW = 64 - DEC_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_EXTRACT = 4'b0010,
        S_SIGN    = 4'b0100,
        S_EMIT    = 4'b1000
    } t_state;

    t_state               r_state, n_state;
    logic [63:0]          r_val, n_val;
    logic                 r_hex, r_upper, r_neg;
    logic [DIG_IDX_W-1:0] r_wr, n_wr;
    logic [DIG_IDX_W-1:0] r_rd, n_rd;
    logic [4:0]           r_cnt, n_cnt;
    logic [3:0]           r_dig [DIGITS_MAX];

    logic [63:0]          w_prod;
    logic [QuotW-1:0]     w_quot;
    logic [31:0]          w_quot10;
    logic [31:0]          w_rem;
    logic [3:0]           w_digit;
    logic [63:0]          w_next;
    logic                 w_done;
    logic                 w_load;
    logic                 w_dig_wr;
    logic [3:0]           w_rd_dig;
    logic [7:0]           w_ofs;
    logic                 w_last;

    // Divide by ten through a reciprocal multiply; the remainder is the digit.
    assign w_prod   = 64'(r_val[31:0]) * 64'(DEC_RECIP);
    assign w_quot   = w_prod[63:DEC_SHIFT];
    assign w_quot10 = (32'(w_quot) << 3) + (32'(w_quot) << 1);
    assign w_rem    = r_val[31:0] - w_quot10;

    // Hexadecimal takes a nibble, decimal takes the remainder.
    assign w_digit = r_hex ? r_val[3:0] : w_rem[3:0];
    assign w_next  = r_hex ? {4'd0, r_val[63:4]} : 64'(w_quot);
    assign w_done  = (w_next == '0) || (r_wr == DIG_IDX_W'(DIGITS_MAX - 1));

    // Character for the digit being emitted.
    assign w_rd_dig = r_dig[r_rd];
    assign w_ofs    = (w_rd_dig < DEC_RADIX) ? ASCII_ZERO
                    : (r_upper ? ASCII_UPPER_OFS : ASCII_LOWER_OFS);
    assign w_last   = (r_rd == '0);

    assign w_load    = (r_state == S_IDLE) & i_job_valid;
    assign o_job_pop = w_load;
    assign w_dig_wr  = (r_state == S_EXTRACT);

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_val      = r_val;
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_cnt      = r_cnt;
        o_res_push = 1'b0;
        o_res.ch    = {4'd0, w_rd_dig} + w_ofs;
        o_res.last  = w_last;
        o_res.count = r_cnt + 1'b1;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_val   = i_job.value;
                    n_wr    = '0;
                    n_state = S_EXTRACT;
                end
            end
            S_EXTRACT: begin
                n_val = w_next;
                n_wr  = r_wr + 1'b1;
                if (w_done) begin
                    n_rd    = r_wr;
                    n_cnt   = '0;
                    n_state = r_neg ? S_SIGN : S_EMIT;
                end
            end
            S_SIGN: begin
                o_res.ch   = ASCII_MINUS;
                o_res.last = 1'b0;
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    n_state    = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!i_res_full) begin
                    o_res_push = 1'b1;
                    n_cnt      = r_cnt + 1'b1;
                    n_rd       = r_rd - 1'b1;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_stat.idle = (r_state == S_IDLE);
    assign o_stat.push = o_res_push;
    assign o_stat.pop  = o_job_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers for the number in progress.
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_wr  <= n_wr;
        r_rd  <= n_rd;
        r_cnt <= n_cnt;
        if (w_load) begin
            r_hex   <= i_job.hex;
            r_upper <= i_job.upper;
            r_neg   <= i_job.neg;
        end
    end

    // Digit buffer, least significant digit first.
    always_ff @(posedge i_clk) begin
        if (w_dig_wr) begin
            r_dig[r_wr] <= w_digit;
        end
    end

endmodule

`default_nettype wire
